FILE: design/assert_macros.svh
// Assertion macros shared by the generator RTL.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: design/skpg_pkg.sv
// Package for the sorted k-permutation generator: request codes, widths,
// controller state type and the command/status structs. No dependencies.
package skpg_pkg;

  localparam int MAX_ITEMS_DEF  = 8;
  localparam int VALUE_BITS_DEF = 16;
  localparam int CFG_W          = 4;
  localparam int POS_W          = 3;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  // Request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_NEXT  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Register word indexes
  localparam logic REG_ITEM_COUNT   = 1'b0;
  localparam logic REG_TUPLE_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_EMIT,
    ST_EXH
  } skpg_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic fill_init;
    logic scan_init;
    logic scan;
    logic fill;
    logic emit;
    logic emit_exh;
  } skpg_cmd_t;

  typedef struct packed {
    logic too_long;
    logic found;
    logic idx_last;
    logic idx_zero;
  } skpg_status_t;

endpackage

FILE: design/sorted_k_permutation_generator_core.sv
// Load and clear requests leave the block idle and can be issued on consecutive cycles.
// A next request fills all k positions and then emits k elements for the first tuple;
// later ones scan back for a position to advance, fill the positions after it and emit
// k elements; the scan/fill sequencer finds one position per cycle. The exhausted result
// is a single result. Results appear in the cycle after the sequencer's emit step, one per
// cycle. Synchronous reset empties the store, restarts enumeration and sets both registers to 1.
`include "assert_macros.svh"

module sorted_k_permutation_generator_core import skpg_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  strobe,
  output logic [VALUE_BITS-1:0] element,
  output logic [POS_W-1:0]      position,
  output logic                  end_of_tuple,
  output logic                  exhausted,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] item_count;
  logic [CFG_W-1:0] tuple_length;
  logic             cfg_wr;
  skpg_cmd_t        cmd;
  skpg_status_t     status;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count   <= CFG_W'(1);
      tuple_length <= CFG_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ITEM_COUNT) begin
        item_count <= pwdata[CFG_W-1:0];
      end else begin
        tuple_length <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Register read
  assign prdata = (paddr[2] == REG_TUPLE_LENGTH) ? DATA_W'(tuple_length)
                                                 : DATA_W'(item_count);

  skpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .cfg_wr   (cfg_wr),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  skpg_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item_count   (item_count),
    .tuple_length (tuple_length),
    .value        (value),
    .status       (status),
    .strobe       (strobe),
    .element      (element),
    .position     (position),
    .end_of_tuple (end_of_tuple),
    .exhausted    (exhausted)
  );

  // Results only follow sequencer activity
  `ASSERT_CLK(a_strobe_after_busy, !strobe || $past(busy), "result without active request")
  // Accepted next request always occupies the sequencer
  `ASSERT_NEXT(a_next_busy, start && !busy && req_type == REQ_NEXT, busy, "next request not taken")
  // Tuple elements come out back to back
  `ASSERT_NEXT(a_tuple_contig, strobe && !end_of_tuple, strobe, "gap inside tuple")
  // Exhausted result stands alone
  `ASSERT_NEXT(a_exh_single, strobe && exhausted, !strobe, "repeated exhausted result")

endmodule

FILE: design/skpg_dp.sv
// Datapath of the sorted k-permutation generator: sorted value store, chosen
// positions, used mask, step counter and result registers. Uses skpg_pkg.
module skpg_dp import skpg_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  skpg_cmd_t             cmd,
  input  logic [CFG_W-1:0]      item_count,
  input  logic [CFG_W-1:0]      tuple_length,
  input  logic [VALUE_BITS-1:0] value,
  output skpg_status_t          status,
  output logic                  strobe,
  output logic [VALUE_BITS-1:0] element,
  output logic [POS_W-1:0]      position,
  output logic                  end_of_tuple,
  output logic                  exhausted
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [VALUE_BITS-1:0] store [MAX_ITEMS];
  logic [VALUE_BITS-1:0] ins_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]  ins_gt;
  logic [CNT_W-1:0]      loaded_count;
  logic [IDX_W-1:0]      chosen [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]  used, used_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]      n_eff;
  logic [IDX_W-1:0]      cur;
  logic [MAX_ITEMS-1:0]  used_wo;
  logic [MAX_ITEMS-1:0]  cand;
  logic [MAX_ITEMS-1:0]  free;
  logic [IDX_W-1:0]      scan_v;
  logic [IDX_W-1:0]      fill_c;
  logic                  found;
  logic                  idx_last;

  assign cur = chosen[idx];

  // Effective item count: smallest of register, loaded count and capacity
  always_comb begin
    if (int'(item_count) > MAX_ITEMS) begin
      n_eff = CNT_W'(MAX_ITEMS);
    end else begin
      n_eff = CNT_W'(item_count);
    end
    if (loaded_count < n_eff) begin
      n_eff = loaded_count;
    end
  end

  // Sorted insert: each entry keeps, takes the new value or takes its neighbor
  always_comb begin
    for (int j = 0; j < MAX_ITEMS; j++) begin
      ins_gt[j] = (j >= int'(loaded_count)) || (store[j] > value);
    end
    for (int j = 0; j < MAX_ITEMS; j++) begin
      if (!ins_gt[j]) begin
        ins_val[j] = store[j];
      end else if (j > 0 && ins_gt[(j > 0) ? j - 1 : 0]) begin
        ins_val[j] = store[(j > 0) ? j - 1 : 0];
      end else begin
        ins_val[j] = value;
      end
    end
  end

  // Candidate masks for the next free position above the current one
  always_comb begin
    used_wo = used;
    for (int b = 0; b < MAX_ITEMS; b++) begin
      if (b == int'(cur)) begin
        used_wo[b] = 1'b0;
      end
      cand[b] = !used_wo[b] && (b > int'(cur)) && (b < int'(n_eff));
      free[b] = !used[b] && (b < int'(n_eff));
    end
  end

  // Lowest set bit of each mask
  always_comb begin
    scan_v = '0;
    fill_c = '0;
    for (int b = MAX_ITEMS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        scan_v = IDX_W'(b);
      end
      if (free[b]) begin
        fill_c = IDX_W'(b);
      end
    end
  end

  assign found    = |cand;
  assign idx_last = (CFG_W'(idx) == tuple_length - CFG_W'(1));

  assign status.too_long = (tuple_length == '0) || (int'(tuple_length) > int'(n_eff));
  assign status.found    = found;
  assign status.idx_last = idx_last;
  assign status.idx_zero = (idx == '0);

  // Next used mask and step counter
  always_comb begin
    used_next = used;
    idx_next  = idx;
    if (cmd.fill_init) begin
      used_next = '0;
      idx_next  = '0;
    end else if (cmd.scan_init) begin
      idx_next = IDX_W'(tuple_length - CFG_W'(1));
    end else if (cmd.scan) begin
      if (found) begin
        used_next = used_wo | (MAX_ITEMS'(1) << scan_v);
        idx_next  = idx_last ? '0 : idx + IDX_W'(1);
      end else begin
        used_next = used_wo;
        idx_next  = idx - IDX_W'(1);
      end
    end else if (cmd.fill) begin
      used_next = used | (MAX_ITEMS'(1) << fill_c);
      idx_next  = idx_last ? '0 : idx + IDX_W'(1);
    end else if (cmd.emit) begin
      idx_next = idx_last ? '0 : idx + IDX_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      idx          <= '0;
      strobe       <= 1'b0;
    end else begin
      idx    <= idx_next;
      strobe <= cmd.emit | cmd.emit_exh;
      if (cmd.clear) begin
        loaded_count <= '0;
      end else if (cmd.load && int'(loaded_count) < MAX_ITEMS) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
    end
  end

  // Store, chosen positions, used mask and result fields
  always_ff @(posedge clk) begin
    used <= used_next;
    if (cmd.load && int'(loaded_count) < MAX_ITEMS) begin
      for (int j = 0; j < MAX_ITEMS; j++) begin
        store[j] <= ins_val[j];
      end
    end
    if (cmd.scan && found) begin
      chosen[idx] <= scan_v;
    end else if (cmd.fill) begin
      chosen[idx] <= fill_c;
    end
    if (cmd.emit) begin
      element      <= store[cur];
      position     <= POS_W'(idx);
      end_of_tuple <= idx_last;
      exhausted    <= 1'b0;
    end else if (cmd.emit_exh) begin
      element      <= '0;
      position     <= '0;
      end_of_tuple <= 1'b1;
      exhausted    <= 1'b1;
    end
  end

endmodule

FILE: design/skpg_ctrl.sv
// Controller of the sorted k-permutation generator: request decode and the
// scan/fill/emit sequencer, with enumeration flags. Uses skpg_pkg.
module skpg_ctrl import skpg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [1:0]   req_type,
  input  logic         cfg_wr,
  input  skpg_status_t status,
  output skpg_cmd_t    cmd,
  output logic         busy
);

  skpg_state_t state, state_next;
  logic        started, started_next;
  logic        done, done_next;

  // State and enumeration flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
      done    <= done_next;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    started_next = started;
    done_next    = done;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_LOAD, REQ_CLEAR: begin
              started_next = 1'b0;
              done_next    = 1'b0;
            end
            REQ_NEXT: begin
              if (done) begin
                state_next = ST_EXH;
              end else if (status.too_long) begin
                done_next  = 1'b1;
                state_next = ST_EXH;
              end else if (!started) begin
                started_next = 1'b1;
                state_next   = ST_FILL;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (status.found) begin
          state_next = status.idx_last ? ST_EMIT : ST_FILL;
        end else if (status.idx_zero) begin
          done_next  = 1'b1;
          state_next = ST_EXH;
        end
      end
      ST_FILL: begin
        if (status.idx_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_EXH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Register write restarts the enumeration
    if (cfg_wr) begin
      started_next = 1'b0;
      done_next    = 1'b0;
    end
  end

  // Datapath commands
  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_LOAD:  cmd.load  = 1'b1;
            REQ_CLEAR: cmd.clear = 1'b1;
            REQ_NEXT: begin
              if (!done && !status.too_long) begin
                if (!started) begin
                  cmd.fill_init = 1'b1;
                end else begin
                  cmd.scan_init = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: cmd.scan     = 1'b1;
      ST_FILL: cmd.fill     = 1'b1;
      ST_EMIT: cmd.emit     = 1'b1;
      ST_EXH:  cmd.emit_exh = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: test/tb_sorted_k_permutation_generator_core.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_k_permutation_generator_core: directed and random
// load/next/clear requests plus APB register writes. Depends on skpg_pkg.
module tb_sorted_k_permutation_generator_core import skpg_pkg::*; ();

  localparam int SLOTS          = MAX_ITEMS_DEF;
  localparam int VW             = VALUE_BITS_DEF;
  localparam int ITEM_TARGET    = 420;
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 300000;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [ADDR_W-1:0] ITEM_COUNT_ADDR   = ADDR_W'(4 * int'(REG_ITEM_COUNT));
  localparam logic [ADDR_W-1:0] TUPLE_LENGTH_ADDR = ADDR_W'(4 * int'(REG_TUPLE_LENGTH));

  // One host operation: either a request or a register write
  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        kind;
    logic [VW-1:0]     val;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } host_cmd_t;

  // One emitted tuple element
  typedef struct packed {
    logic [VW-1:0]    element;
    logic [POS_W-1:0] position;
    logic             last;
    logic             exh;
  } tuple_elem_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        req_type = '0;
  logic [VW-1:0]     value = '0;
  logic              strobe;
  logic [VW-1:0]     element;
  logic [POS_W-1:0]  position;
  logic              end_of_tuple;
  logic              exhausted;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  host_cmd_t   pending_cmds[$];
  tuple_elem_t tuple_elems_due[$];
  host_cmd_t   active_cmd = '0;

  // Shadow of the block state
  logic [VW-1:0] sorted_vals [SLOTS];
  int            sel_idx [SLOTS];
  int            stored_cnt = 0;
  bit            enum_started = 0;
  bit            enum_done = 0;
  int            cfg_count = 1;
  int            cfg_len = 1;

  bit in_flight = 0;
  int apb_phase = 0;
  int gap_left = 0;
  int quiet_cycles = 0;
  int no_idle_run = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int requests_queued = 0;
  int gen_loaded = 0;
  logic [VW-1:0] last_loaded = '0;

  sorted_k_permutation_generator_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .value        (value),
    .strobe       (strobe),
    .element      (element),
    .position     (position),
    .end_of_tuple (end_of_tuple),
    .exhausted    (exhausted),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True when position v already appears among the first upto tuple slots
  function automatic bit taken_before(int upto, int v);
    for (int i = 0; i < upto && i < SLOTS; i++) begin
      if (sel_idx[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Move the selection to the next tuple in lexicographic order
  function automatic bit step_selection(int n, int k);
    int i, v, c;
    i = k;
    while (i > 0) begin
      i--;
      v = sel_idx[i] + 1;
      while (v < n && taken_before(i, v)) v++;
      if (v < n) begin
        sel_idx[i] = v;
        for (int j = i + 1; j < k && j < SLOTS; j++) begin
          c = 0;
          while (c < n && taken_before(j, c)) c++;
          sel_idx[j] = c;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Update the shadow state for one accepted request and queue its tuple elements
  task automatic compute_tuple_elems(logic [1:0] kind, logic [VW-1:0] val);
    int n, k, p;
    tuple_elem_t e;
    case (kind)
      REQ_LOAD: begin
        if (stored_cnt < SLOTS) begin
          p = stored_cnt;
          while (p > 0 && sorted_vals[p-1] > val) begin
            sorted_vals[p] = sorted_vals[p-1];
            p--;
          end
          sorted_vals[p] = val;
          stored_cnt++;
        end
        enum_started = 0;
        enum_done = 0;
      end
      REQ_CLEAR: begin
        stored_cnt = 0;
        enum_started = 0;
        enum_done = 0;
      end
      REQ_NEXT: begin
        n = cfg_count;
        if (n > stored_cnt) n = stored_cnt;
        if (n > SLOTS) n = SLOTS;
        k = cfg_len;
        if (!enum_done) begin
          if (!enum_started) begin
            if (k == 0 || k > n) begin
              enum_done = 1;
            end else begin
              for (int i = 0; i < k && i < SLOTS; i++) sel_idx[i] = i;
              enum_started = 1;
            end
          end else if (k == 0 || k > n || !step_selection(n, k)) begin
            enum_done = 1;
          end
        end
        if (enum_done) begin
          e = '{element: '0, position: '0, last: 1'b1, exh: 1'b1};
          tuple_elems_due.push_back(e);
        end else begin
          for (int i = 0; i < k && i < SLOTS; i++) begin
            e.element  = sorted_vals[sel_idx[i] % SLOTS];
            e.position = POS_W'(i);
            e.last     = (i + 1 == k);
            e.exh      = 1'b0;
            tuple_elems_due.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Apply a completed register write to the shadow configuration
  task automatic apply_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    if (addr == ITEM_COUNT_ADDR) begin
      cfg_count = int'(data[CFG_W-1:0]);
    end else if (addr == TUPLE_LENGTH_ADDR) begin
      cfg_len = int'(data[CFG_W-1:0]);
    end else begin
      return;
    end
    enum_started = 0;
    enum_done = 0;
  endtask

  // Idle gap before the next operation: mostly none or short, a few long, some bursts
  function automatic int draw_gap();
    int r;
    if (no_idle_run > 0) begin
      no_idle_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      no_idle_run = $urandom_range(8, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic push_request(logic [1:0] kind, logic [VW-1:0] val);
    host_cmd_t c;
    c = '0;
    c.kind = kind;
    c.val = val;
    pending_cmds.push_back(c);
    if (kind != REQ_UNKNOWN) requests_queued++;
    if (kind == REQ_LOAD) last_loaded = val;
  endtask

  task automatic push_register(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] v);
    host_cmd_t c;
    c = '0;
    c.is_cfg = 1'b1;
    c.addr = addr;
    c.data = DATA_W'(v);
    // Upper bits are don't-care; toggle them now and then
    if ($urandom_range(0, 3) == 0) c.data[DATA_W-1:CFG_W] = (DATA_W-CFG_W)'($urandom);
    pending_cmds.push_back(c);
  endtask

  // Load values: extremes, repeats of the previous one, and plain random
  function automatic logic [VW-1:0] draw_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return last_loaded;
    return VW'($urandom);
  endfunction

  // Driver: present requests with start, run APB writes only while the block is quiet
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      in_flight = 0;
      apb_phase = 0;
      gap_left = 0;
      quiet_cycles = 0;
    end else begin
      // retire the accepted request
      if (start && !busy) begin
        compute_tuple_elems(req_type, value);
        in_flight = 0;
        gap_left = draw_gap();
      end
      // advance the register write
      if (apb_phase == 2 && psel && penable && pwrite && pready) begin
        apply_register(paddr, pwdata);
        apb_phase = 0;
        gap_left = draw_gap();
      end else if (apb_phase == 1) begin
        apb_phase = 2;
      end
      // count cycles with nothing outstanding
      if (!in_flight && !busy && !strobe && tuple_elems_due.size() == 0) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      // pick up the next operation
      if (!in_flight && apb_phase == 0 && pending_cmds.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_cmds[0].is_cfg) begin
          active_cmd = pending_cmds.pop_front();
          in_flight = 1;
        end else if (quiet_cycles >= SETTLE_CYCLES) begin
          active_cmd = pending_cmds.pop_front();
          apb_phase = 1;
        end
      end
      start    <= in_flight;
      req_type <= active_cmd.kind;
      value    <= active_cmd.val;
      psel     <= (apb_phase != 0);
      penable  <= (apb_phase == 2);
      pwrite   <= (apb_phase != 0);
      paddr    <= active_cmd.addr;
      pwdata   <= active_cmd.data;
    end
  end

  // Monitor: compare every strobed element with the oldest expected one
  always @(posedge clk) begin
    tuple_elem_t want;
    if (!rst && strobe) begin
      if (tuple_elems_due.size() == 0) begin
        report_mismatch($sformatf("unexpected element %h position %0d eot %b exh %b",
                                  element, position, end_of_tuple, exhausted));
      end else begin
        want = tuple_elems_due.pop_front();
        if (element !== want.element)
          report_mismatch($sformatf("element got %h want %h at position %0d",
                                    element, want.element, want.position));
        if (position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d", position, want.position));
        if (end_of_tuple !== want.last)
          report_mismatch($sformatf("end_of_tuple got %b want %b at position %0d",
                                    end_of_tuple, want.last, want.position));
        if (exhausted !== want.exh)
          report_mismatch($sformatf("exhausted got %b want %b", exhausted, want.exh));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r, n_loads, n_cfg, n_eff, k, span, nexts, cap;

    // Directed: default registers with one value, single-element tuples run out
    push_request(REQ_LOAD, 16'h1234);
    push_request(REQ_NEXT, VW'($urandom));
    push_request(REQ_NEXT, VW'($urandom));
    // Out-of-order loads, extremes, an unknown request
    push_request(REQ_LOAD, 16'hFFFF);
    push_request(REQ_LOAD, 16'h0000);
    push_request(REQ_LOAD, 16'h8000);
    push_request(REQ_UNKNOWN, 16'hA5A5);
    // Three of four values used, pairs: all six tuples then exhausted
    push_register(ITEM_COUNT_ADDR, 4'd3);
    push_register(TUPLE_LENGTH_ADDR, 4'd2);
    repeat (7) push_request(REQ_NEXT, VW'($urandom));
    // Empty tuple and too long tuple are exhausted at once
    push_register(TUPLE_LENGTH_ADDR, 4'd0);
    push_request(REQ_NEXT, VW'($urandom));
    push_register(TUPLE_LENGTH_ADDR, 4'd4);
    push_request(REQ_NEXT, VW'($urandom));
    // Fill the store; the last load is dropped
    push_request(REQ_LOAD, 16'h0001);
    push_request(REQ_LOAD, 16'h7FFF);
    push_request(REQ_LOAD, 16'h8000);
    push_request(REQ_LOAD, 16'hFFFE);
    push_request(REQ_LOAD, 16'h0000);
    push_register(ITEM_COUNT_ADDR, 4'd8);
    push_register(TUPLE_LENGTH_ADDR, 4'd8);
    push_request(REQ_NEXT, VW'($urandom));
    // Clear, then nothing to select
    push_request(REQ_CLEAR, VW'($urandom));
    push_request(REQ_NEXT, VW'($urandom));
    gen_loaded = 0;

    // Random phases: load a set, pick registers, walk the enumeration
    while (requests_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 4) != 0) begin
        push_request(REQ_CLEAR, VW'($urandom));
        gen_loaded = 0;
      end
      r = $urandom_range(0, 9);
      if (r < 6) n_loads = $urandom_range(1, 4);
      else if (r < 9) n_loads = $urandom_range(5, 8);
      else n_loads = $urandom_range(9, 10);
      repeat (n_loads) begin
        push_request(REQ_LOAD, draw_value());
        if (gen_loaded < SLOTS) gen_loaded++;
      end

      r = $urandom_range(0, 9);
      if (r < 7) n_cfg = gen_loaded;
      else if (r == 7) n_cfg = 0;
      else if (r == 8) n_cfg = 15;
      else n_cfg = $urandom_range(0, 15);
      n_eff = n_cfg;
      if (n_eff > gen_loaded) n_eff = gen_loaded;
      if (n_eff > SLOTS) n_eff = SLOTS;

      r = $urandom_range(0, 11);
      if (r < 9 && n_eff > 0) k = $urandom_range(1, n_eff);
      else if (r == 9) k = 0;
      else if (r == 10) k = n_eff + 1;
      else k = $urandom_range(0, 15);
      push_register(ITEM_COUNT_ADDR, CFG_W'(n_cfg));
      push_register(TUPLE_LENGTH_ADDR, CFG_W'(k));

      // tuples available, saturated well above any cap
      span = (k == 0 || k > n_eff) ? 0 : 1;
      for (int i = 0; i < k && span != 0 && span < 1000; i++) span *= (n_eff - i);
      nexts = span + $urandom_range(1, 2);
      cap = $urandom_range(10, 30);
      if (nexts > cap) nexts = cap;

      repeat (nexts) begin
        r = $urandom_range(0, 29);
        if (r == 0) begin
          push_request(REQ_LOAD, draw_value());
          if (gen_loaded < SLOTS) gen_loaded++;
        end else if (r == 1) begin
          push_request(REQ_UNKNOWN, VW'($urandom));
        end else begin
          push_request(REQ_NEXT, VW'($urandom));
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || in_flight || apb_phase != 0 ||
           tuple_elems_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
